@@ design/fsc_pkg.sv @@
package fsc_pkg;

  localparam int COUNT_WIDTH = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_GT  = 8'h3E;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_C   = 8'h43;
  localparam logic [7:0] CHAR_G   = 8'h47;
  localparam logic [7:0] CHAR_T   = 8'h54;

  // Saturating increment at the counter width.
  function automatic count_t count_bump(count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  // Report a counter clipped to 32 bits.
  function automatic logic [31:0] count_report(count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

@@ design/fasta_sequence_cleaner.sv @@
// FASTA / plain reference cleaner.
//
// Input channel (in_valid/in_ready): one raw byte per transfer on data_byte,
// or an end marker with end_of_input set (data_byte ignored). NULs, header
// lines ('>' at line start up to CR/LF) and whitespace are dropped; other
// bytes come out as bases, A/C/G/T unchanged and anything else as 'A'.
// Output channel (out_valid/out_ready): exactly one result per input
// transfer, carrying base_valid/base_char and the five running counts. The
// result of an end marker has done_res set, empty_error when no base was
// seen, and the state clears behind it.
//
// Two register stages: an input register and the result register, with the
// per-byte classification and counter updates between them. A transfer goes
// into the input register, then its result into the result register; one
// transfer per cycle is sustained on both sides while out_ready stays high.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_ready drops; it rises again in the cycle the
// receiver takes the result.
// Reset (rst, synchronous) empties both stages, clears all counters and
// returns the parser to the start of a line outside any header.
module fasta_sequence_cleaner
  import fsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        base_valid,
  output logic [7:0]  base_char,
  output logic [31:0] base_total,
  output logic [31:0] replace_total,
  output logic [31:0] header_count,
  output logic [31:0] whitespace_count,
  output logic [31:0] nul_count,
  output logic        done_res,
  output logic        empty_error
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;

  // parser state
  logic   line_start_flag, line_start_flag_next;
  logic   in_header_flag, in_header_flag_next;
  count_t base_counter, base_counter_next;
  count_t replace_counter, replace_counter_next;
  count_t header_counter, header_counter_next;
  count_t space_counter, space_counter_next;
  count_t nul_counter, nul_counter_next;

  logic       s1_advance;
  logic       bv_next;
  logic [7:0] ch_next;
  logic       eol, is_space, is_acgt;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_end  <= end_of_input;
    end
  end

  assign eol      = (s1_byte == CHAR_LF) || (s1_byte == CHAR_CR);
  assign is_space = ((s1_byte >= CHAR_TAB) && (s1_byte <= CHAR_CR)) || (s1_byte == CHAR_SP);
  assign is_acgt  = (s1_byte == CHAR_A) || (s1_byte == CHAR_C) ||
                    (s1_byte == CHAR_G) || (s1_byte == CHAR_T);

  always_comb begin
    line_start_flag_next = line_start_flag;
    in_header_flag_next  = in_header_flag;
    base_counter_next    = base_counter;
    replace_counter_next = replace_counter;
    header_counter_next  = header_counter;
    space_counter_next   = space_counter;
    nul_counter_next     = nul_counter;
    bv_next              = 1'b0;
    ch_next              = CHAR_NUL;
    if (s1_end) begin
      line_start_flag_next = 1'b1;
      in_header_flag_next  = 1'b0;
      base_counter_next    = '0;
      replace_counter_next = '0;
      header_counter_next  = '0;
      space_counter_next   = '0;
      nul_counter_next     = '0;
    end else if (s1_byte == CHAR_NUL) begin
      nul_counter_next = count_bump(nul_counter);
    end else if (in_header_flag) begin
      if (eol) begin
        in_header_flag_next  = 1'b0;
        line_start_flag_next = 1'b1;
      end
    end else if (line_start_flag && (s1_byte == CHAR_GT)) begin
      in_header_flag_next = 1'b1;
      header_counter_next = count_bump(header_counter);
    end else if (is_space) begin
      space_counter_next = count_bump(space_counter);
      if (eol) begin
        line_start_flag_next = 1'b1;
      end
    end else begin
      line_start_flag_next = 1'b0;
      bv_next              = 1'b1;
      base_counter_next    = count_bump(base_counter);
      if (is_acgt) begin
        ch_next = s1_byte;
      end else begin
        ch_next              = CHAR_A;
        replace_counter_next = count_bump(replace_counter);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_start_flag <= 1'b1;
      in_header_flag  <= 1'b0;
      base_counter    <= '0;
      replace_counter <= '0;
      header_counter  <= '0;
      space_counter   <= '0;
      nul_counter     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_advance) begin
        line_start_flag <= line_start_flag_next;
        in_header_flag  <= in_header_flag_next;
        base_counter    <= base_counter_next;
        replace_counter <= replace_counter_next;
        header_counter  <= header_counter_next;
        space_counter   <= space_counter_next;
        nul_counter     <= nul_counter_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register; on an end marker the counts are the totals before clearing
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      base_valid       <= bv_next;
      base_char        <= ch_next;
      base_total       <= count_report(s1_end ? base_counter : base_counter_next);
      replace_total    <= count_report(s1_end ? replace_counter : replace_counter_next);
      header_count     <= count_report(s1_end ? header_counter : header_counter_next);
      whitespace_count <= count_report(s1_end ? space_counter : space_counter_next);
      nul_count        <= count_report(s1_end ? nul_counter : nul_counter_next);
      done_res         <= s1_end;
      empty_error      <= s1_end && (base_counter == '0);
    end
  end

  a_base_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_valid |-> (base_char == CHAR_A) || (base_char == CHAR_C) ||
                                (base_char == CHAR_G) || (base_char == CHAR_T))
    else $error("emitted base is not A/C/G/T");

  a_done_no_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !base_valid)
    else $error("end result carries a base");

  a_empty_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_error |-> done_res && (base_total == 32'd0))
    else $error("empty flag without end or with bases counted");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_end |=> (base_counter == '0) && line_start_flag && !in_header_flag)
    else $error("state not cleared after end marker");

  a_base_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_valid |-> base_total != 32'd0)
    else $error("base emitted with zero length");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(base_char) && $stable(base_total))
    else $error("stalled result changed");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fsc_pkg::*;

  localparam int ITEMS      = 1550;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic        base_valid;
    logic [7:0]  base_char;
    logic [31:0] base_total;
    logic [31:0] replace_total;
    logic [31:0] header_count;
    logic [31:0] whitespace_count;
    logic [31:0] nul_count;
    logic        done_res;
    logic        empty_error;
  } clean_result_t;

  // Tracks the cleaner's parse state and counters, queues the expected
  // result of every input transfer and checks results in order.
  class fasta_scoreboard;
    bit            line_start;
    bit            in_header;
    count_t        bases, replaced, headers, spaces, nuls;
    clean_result_t expected_results[$];
    int            mismatches;
    int            checked;

    function new();
      clear_state();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void clear_state();
      line_start = 1'b1;
      in_header  = 1'b0;
      bases      = '0;
      replaced   = '0;
      headers    = '0;
      spaces     = '0;
      nuls       = '0;
    endfunction

    function count_t saturating_inc(count_t c);
      return (&c) ? c : c + count_t'(1);
    endfunction

    function logic [31:0] clip32(count_t c);
      logic [63:0] wide;
      wide = 64'(c);
      return (wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function void note_byte(logic [7:0] b, logic eoi);
      clean_result_t r;
      r = '0;
      if (!eoi) begin
        if (b == CHAR_NUL) begin
          nuls = saturating_inc(nuls);
        end else if (in_header) begin
          if (b == CHAR_LF || b == CHAR_CR) begin
            in_header  = 1'b0;
            line_start = 1'b1;
          end
        end else if (line_start && b == CHAR_GT) begin
          in_header = 1'b1;
          headers   = saturating_inc(headers);
        end else if ((b >= CHAR_TAB && b <= CHAR_CR) || b == CHAR_SP) begin
          spaces = saturating_inc(spaces);
          if (b == CHAR_LF || b == CHAR_CR)
            line_start = 1'b1;
        end else begin
          line_start   = 1'b0;
          r.base_valid = 1'b1;
          if (b == CHAR_A || b == CHAR_C || b == CHAR_G || b == CHAR_T) begin
            r.base_char = b;
          end else begin
            r.base_char = CHAR_A;
            replaced    = saturating_inc(replaced);
          end
          bases = saturating_inc(bases);
        end
      end
      r.base_total       = clip32(bases);
      r.replace_total    = clip32(replaced);
      r.header_count     = clip32(headers);
      r.whitespace_count = clip32(spaces);
      r.nul_count        = clip32(nuls);
      r.done_res         = eoi;
      r.empty_error      = eoi && (bases == '0);
      expected_results.insert(expected_results.size(), r);
      if (eoi)
        clear_state();
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("tb: result %0d, %s: expected %0h, got %0h", checked, name, want, got);
      end
    endfunction

    function void check_result(clean_result_t got);
      clean_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("tb: result with no transfer pending: %p", got);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      field_check("base_valid", 32'(want.base_valid), 32'(got.base_valid));
      field_check("base_char", 32'(want.base_char), 32'(got.base_char));
      field_check("base_total", want.base_total, got.base_total);
      field_check("replace_total", want.replace_total, got.replace_total);
      field_check("header_count", want.header_count, got.header_count);
      field_check("whitespace_count", want.whitespace_count, got.whitespace_count);
      field_check("nul_count", want.nul_count, got.nul_count);
      field_check("done_res", 32'(want.done_res), 32'(got.done_res));
      field_check("empty_error", 32'(want.empty_error), 32'(got.empty_error));
    endfunction
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte    = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        base_valid;
  logic [7:0]  base_char;
  logic [31:0] base_total;
  logic [31:0] replace_total;
  logic [31:0] header_count;
  logic [31:0] whitespace_count;
  logic [31:0] nul_count;
  logic        done_res;
  logic        empty_error;

  fasta_scoreboard sb = new();

  int items_sent  = 0;
  int ends_sent   = 0;
  int bases_out   = 0;
  int empties_out = 0;
  int idle_cycles = 0;
  int run_left    = 0;
  bit steady_run  = 1'b0;

  fasta_sequence_cleaner i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .end_of_input     (end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .base_valid       (base_valid),
    .base_char        (base_char),
    .base_total       (base_total),
    .replace_total    (replace_total),
    .header_count     (header_count),
    .whitespace_count (whitespace_count),
    .nul_count        (nul_count),
    .done_res         (done_res),
    .empty_error      (empty_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Sender gaps come in runs; some runs have no gaps at all.
  function automatic int sender_gap();
    if (run_left == 0) begin
      steady_run = ($urandom_range(0, 6) == 0);
      run_left   = $urandom_range(20, 100);
    end
    run_left--;
    return steady_run ? 0 : random_gap();
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, eoi);
    items_sent++;
    if (eoi)
      ends_sent++;
  endtask

  task automatic send_line_end();
    case ($urandom_range(0, 2))
      0: send_item(CHAR_LF, 1'b0);
      1: send_item(CHAR_CR, 1'b0);
      default: begin
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
    endcase
  endtask

  function automatic logic [7:0] sequence_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return CHAR_A;
        1: return CHAR_C;
        2: return CHAR_G;
        default: return CHAR_T;
      endcase
    end
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return "a";
        1: return "c";
        2: return "g";
        3: return "t";
        default: return "n";
      endcase
    end
    if (r < 93) return "N";
    if (r < 97) return ($urandom_range(0, 1) != 0) ? CHAR_SP : CHAR_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  // One FASTA record: optional header, a few sequence lines, maybe noise.
  task automatic send_record();
    int n;
    int lines;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 4) == 0)
        send_item(($urandom_range(0, 1) != 0) ? CHAR_SP : CHAR_TAB, 1'b0);
      send_item(CHAR_GT, 1'b0);
      n = $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0);
        else
          send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end
      // occasionally leave the header open
      if ($urandom_range(0, 9) != 0)
        send_line_end();
    end
    lines = $urandom_range(0, 4);
    repeat (lines) begin
      n = $urandom_range(0, 25);
      repeat (n) send_item(sequence_byte(), 1'b0);
      send_line_end();
    end
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(5, 20);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int hold;
    int stall;
    @(posedge clk);
    forever begin
      hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      stall = random_gap();
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({base_valid, base_char, base_total, replace_total,
                       header_count, whitespace_count, nul_count, done_res, empty_error});
      if (base_valid === 1'b1)
        bases_out++;
      if (done_res === 1'b1 && empty_error === 1'b1)
        empties_out++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: timeout, no transfer for %0d cycles", idle_cycles);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    bit paused;
    int records;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: bases, replacements, NULs, headers, whitespace, end markers
    send_item(CHAR_A, 1'b0);
    send_item(CHAR_C, 1'b0);
    send_item(CHAR_G, 1'b0);
    send_item(CHAR_T, 1'b0);
    send_item("a", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(CHAR_NUL, 1'b0);
    send_item(CHAR_GT, 1'b0);      // mid-line, becomes a base
    send_item(CHAR_LF, 1'b0);
    send_item(CHAR_GT, 1'b0);      // opens a header
    send_item("x", 1'b0);
    send_item(CHAR_NUL, 1'b0);     // counted, header stays open
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_SP, 1'b0);
    send_item(CHAR_GT, 1'b0);      // header after leading whitespace
    send_item("N", 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_item(8'h0B, 1'b0);
    send_item(8'h0C, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(CHAR_NUL, 1'b1);     // nothing seen since the last end
    send_item(CHAR_GT, 1'b0);
    send_item("Q", 1'b0);
    send_item(8'h5A, 1'b1);        // header only, still empty

    while (items_sent < ITEMS) begin
      records = $urandom_range(1, 3);
      repeat (records) send_record();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      if (!paused && items_sent > ITEMS / 2) begin
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $display("tb: %0d expected results never arrived", sb.expected_results.size());
      sb.mismatches += sb.expected_results.size();
    end

    $display("tb: %0d bytes and %0d end markers sent, %0d results checked",
             items_sent - ends_sent, ends_sent, sb.checked);
    $display("tb: %0d bases out, %0d empty sequences flagged, %0d mismatches",
             bases_out, empties_out, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
design/fsc_pkg.sv
design/fasta_sequence_cleaner.sv
tb/tb.sv
